FILE: design/lcbc_pkg.sv
// Shared types, register indexes and reset constants for the LED chaser.
package lcbc_pkg;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_PERIOD     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_PERIOD     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_COARSE_STEP    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_FINE_STEP      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_FINE_THRESHOLD = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_START_PERIOD   = 3'd5;

   // Register values after reset.
   localparam logic [7:0] MIN_PERIOD_RST     = 8'd3;
   localparam logic [7:0] MAX_PERIOD_RST     = 8'd200;
   localparam logic [7:0] COARSE_STEP_RST    = 8'd20;
   localparam logic [7:0] FINE_STEP_RST      = 8'd5;
   localparam logic [7:0] FINE_THRESHOLD_RST = 8'd25;
   localparam logic [7:0] START_PERIOD_RST   = 8'd100;

   // Button bit positions.
   localparam int unsigned BTN_START  = 0;
   localparam int unsigned BTN_DIR    = 1;
   localparam int unsigned BTN_BOUNCE = 2;
   localparam int unsigned BTN_SLOWER = 6;
   localparam int unsigned BTN_FASTER = 7;

   // LED patterns at the two ends of the row.
   localparam logic [7:0] LED_RIGHT_END = 8'h01;
   localparam logic [7:0] LED_LEFT_END  = 8'h80;

   typedef struct packed {
      logic [7:0] min_period;
      logic [7:0] max_period;
      logic [7:0] coarse_step;
      logic [7:0] fine_step;
      logic [7:0] fine_threshold;
   } lcbc_cfg_type;

   // Configuration seen by the core, plus the immediate period load.
   typedef struct packed {
      lcbc_cfg_type cfg;
      logic         period_load;
      logic [7:0]   period_value;
   } lcbc_csr_type;

   typedef struct packed {
      logic [7:0] led_out;
      logic       is_running;
      logic       moving_left;
      logic [7:0] current_period;
   } lcbc_result_type;

endpackage

FILE: design/led_chaser_with_button_control_top.sv
// Top level of the LED chaser: input register, core and result register.
//
// Each req item is one 10 ms tick with the raw button levels and the switch
// mask. Button rising edges found on one tick act on the next tick: start
// or run/stop, direction, bounce, faster and slower. Every item gives one
// rsp item with the held LED pattern, the running flag, the direction and
// the present period.
// The csr port writes the five configuration registers; writing start_period
// loads the running period at once. Writes are to be made while no item is
// in flight; the block itself does not enforce this.
// An item accepted at a clock edge sits in the input register, passes the
// core logic and is loaded into the result register, which raises rsp_valid.
// The block takes one item per cycle while the receiver does not stall; the
// state update is one short pass of compare, add and shift.
// Reset empties both registers, resets the chaser state, loads the
// register defaults and sets the period to 100 ticks.
// When the receiver stalls, the result register holds its item and the
// input register can still take one more item; then req_ready drops.
module led_chaser_with_button_control_top
   import lcbc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_buttons,
   input  logic [7:0]             req_switch_mask,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_led_out,
   output logic                   rsp_is_running,
   output logic                   rsp_moving_left,
   output logic [7:0]             rsp_current_period,
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata
);

   lcbc_csr_type    csr_bus;
   lcbc_result_type core_result;
   lcbc_result_type rsp_ff;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_buttons_ff;
   logic [7:0] in_mask_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       tick_fire;
   logic       req_fire;

   // Handshake: the input register moves on whenever the result slot frees.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign tick_fire = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;

   assign in_valid_in  = req_fire || (in_valid_ff && !tick_fire);
   assign rsp_valid_in = tick_fire || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers load only on a transfer.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_buttons_ff <= req_buttons;
         in_mask_ff    <= req_switch_mask;
      end
      if (tick_fire) begin
         rsp_ff <= core_result;
      end
   end

   lcbc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr_out   (csr_bus)
   );

   lcbc_core u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_in           (csr_bus),
      .tick_fire        (tick_fire),
      .tick_buttons     (in_buttons_ff),
      .tick_switch_mask (in_mask_ff),
      .result           (core_result)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_led_out        = rsp_ff.led_out;
   assign rsp_is_running     = rsp_ff.is_running;
   assign rsp_moving_left    = rsp_ff.moving_left;
   assign rsp_current_period = rsp_ff.current_period;

endmodule

FILE: design/lcbc_csr.sv
// Configuration register file of the LED chaser.
module lcbc_csr
   import lcbc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata,
   output lcbc_csr_type           csr_out
);

   lcbc_cfg_type cfg_ff;
   lcbc_cfg_type cfg_in;

   // Decode the write; indexes beyond the list leave everything unchanged.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            REG_MIN_PERIOD:     cfg_in.min_period     = csr_wdata;
            REG_MAX_PERIOD:     cfg_in.max_period     = csr_wdata;
            REG_COARSE_STEP:    cfg_in.coarse_step    = csr_wdata;
            REG_FINE_STEP:      cfg_in.fine_step      = csr_wdata;
            REG_FINE_THRESHOLD: cfg_in.fine_threshold = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_period     <= MIN_PERIOD_RST;
         cfg_ff.max_period     <= MAX_PERIOD_RST;
         cfg_ff.coarse_step    <= COARSE_STEP_RST;
         cfg_ff.fine_step      <= FINE_STEP_RST;
         cfg_ff.fine_threshold <= FINE_THRESHOLD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // A start period write goes straight into the running period.
   assign csr_out.cfg          = cfg_ff;
   assign csr_out.period_load  = csr_wen && (csr_index == REG_START_PERIOD);
   assign csr_out.period_value = csr_wdata;

endmodule

FILE: design/lcbc_core.sv
// Chaser state and the single-pass next-state logic for one tick item.
module lcbc_core
   import lcbc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  lcbc_csr_type    csr_in,
   input  logic            tick_fire,
   input  logic [7:0]      tick_buttons,
   input  logic [7:0]      tick_switch_mask,
   output lcbc_result_type result
);

   logic [7:0] prev_buttons_ff, prev_buttons_in;
   logic [7:0] edges_ff, edges_in;
   logic [7:0] pattern_ff, pattern_in;
   logic       started_ff, started_in;
   logic       running_ff, running_in;
   logic       dir_left_ff, dir_left_in;
   logic       bounce_ff, bounce_in;
   logic [7:0] period_ff, period_in;
   logic [7:0] tick_count_ff, tick_count_in;
   logic [7:0] led_hold_ff, led_hold_in;

   logic [7:0] step_up, step_down;
   logic [7:0] period_up;
   logic [8:0] up_limit, down_sum;
   logic       active;

   // Button actions taken from the edges seen on the previous tick.
   always_comb begin
      started_in  = started_ff;
      running_in  = running_ff;
      dir_left_in = dir_left_ff;
      bounce_in   = bounce_ff;
      pattern_in  = pattern_ff;
      if (edges_ff[BTN_START]) begin
         if (!started_ff) begin
            started_in = 1'b1;
            pattern_in = pattern_ff | LED_RIGHT_END;
         end else begin
            running_in = !running_ff;
         end
      end else if (edges_ff[BTN_DIR]) begin
         dir_left_in = !dir_left_ff;
      end
      if (edges_ff[BTN_BOUNCE]) begin
         bounce_in = !bounce_ff;
      end

      // Speed up first, then speed down, each saturating at its limit.
      step_up   = (period_ff > csr_in.cfg.fine_threshold) ?
                  csr_in.cfg.coarse_step : csr_in.cfg.fine_step;
      up_limit  = {1'b0, step_up} + {1'b0, csr_in.cfg.min_period};
      period_up = period_ff;
      if (edges_ff[BTN_FASTER]) begin
         if ({1'b0, period_ff} < up_limit) begin
            period_up = csr_in.cfg.min_period;
         end else begin
            period_up = period_ff - step_up;
         end
      end
      step_down = (period_up > csr_in.cfg.fine_threshold) ?
                  csr_in.cfg.coarse_step : csr_in.cfg.fine_step;
      down_sum  = {1'b0, period_up} + {1'b0, step_down};
      period_in = period_up;
      if (edges_ff[BTN_SLOWER]) begin
         if (down_sum > {1'b0, csr_in.cfg.max_period}) begin
            period_in = csr_in.cfg.max_period;
         end else begin
            period_in = down_sum[7:0];
         end
      end

      // Count ticks, then move the light one place; at an end, turn back in bounce mode or wrap to the other end.
      active        = started_in && running_in;
      tick_count_in = tick_count_ff;
      led_hold_in   = led_hold_ff;
      if (active) begin
         if (tick_count_ff < period_in) begin
            tick_count_in = tick_count_ff + 8'd1;
         end else if (dir_left_in) begin
            if (!pattern_in[7]) begin
               pattern_in    = {pattern_in[6:0], 1'b0};
               tick_count_in = '0;
            end else if (bounce_in) begin
               dir_left_in = 1'b0;
            end else begin
               pattern_in    = LED_RIGHT_END;
               tick_count_in = '0;
            end
         end else begin
            if (!pattern_in[0]) begin
               pattern_in    = {1'b0, pattern_in[7:1]};
               tick_count_in = '0;
            end else if (bounce_in) begin
               dir_left_in = 1'b1;
            end else begin
               pattern_in    = LED_LEFT_END;
               tick_count_in = '0;
            end
         end
         led_hold_in = pattern_in & ~tick_switch_mask;
      end

      edges_in        = tick_buttons & ~prev_buttons_ff;
      prev_buttons_in = tick_buttons;
   end

   // The result leaves with the state that this item produced.
   assign result.led_out        = led_hold_in;
   assign result.is_running     = active;
   assign result.moving_left    = dir_left_in;
   assign result.current_period = period_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_buttons_ff <= '0;
         edges_ff        <= '0;
         pattern_ff      <= '0;
         started_ff      <= 1'b0;
         running_ff      <= 1'b1;
         dir_left_ff     <= 1'b1;
         bounce_ff       <= 1'b0;
         period_ff       <= START_PERIOD_RST;
         tick_count_ff   <= '0;
         led_hold_ff     <= '0;
      end else if (csr_in.period_load) begin
         period_ff <= csr_in.period_value;
      end else if (tick_fire) begin
         prev_buttons_ff <= prev_buttons_in;
         edges_ff        <= edges_in;
         pattern_ff      <= pattern_in;
         started_ff      <= started_in;
         running_ff      <= running_in;
         dir_left_ff     <= dir_left_in;
         bounce_ff       <= bounce_in;
         period_ff       <= period_in;
         tick_count_ff   <= tick_count_in;
         led_hold_ff     <= led_hold_in;
      end
   end

endmodule

FILE: design/lcbc_checker.sv
// Port-level checks for the LED chaser, bound to the top level.
module lcbc_checker
   import lcbc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_led_out,
   input logic       rsp_is_running,
   input logic       rsp_moving_left,
   input logic [7:0] rsp_current_period
);

   // Reset leaves no result pending and the input side open.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("result pending or input blocked after reset");

   // A single light, possibly blanked, is all the chaser can show.
   a_single_led: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0(rsp_led_out))
      else $error("more than one LED lit");

   // A stalled result item stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   // A stalled result item keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_led_out) && $stable(rsp_is_running)
         && $stable(rsp_moving_left) && $stable(rsp_current_period))
      else $error("result payload changed while stalled");

endmodule

bind led_chaser_with_button_control_top lcbc_checker u_lcbc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_led_out        (rsp_led_out),
   .rsp_is_running     (rsp_is_running),
   .rsp_moving_left    (rsp_moving_left),
   .rsp_current_period (rsp_current_period)
);
